// ===== rtl/utt_pkg.sv =====
// Shared types, constants and helpers of the UTF transcoder.
`default_nettype none

package utt_pkg;

  // Encoding codes as they are written to the configuration registers.
  typedef enum logic [2:0] {
    EncUtf8  = 3'd1,
    EncU16Le = 3'd2,
    EncU16Be = 3'd3,
    EncU32Le = 3'd4,
    EncU32Be = 3'd5
  } enc_e;

  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 3;

  localparam logic [CfgIdxW-1:0] CfgSrcEnc = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgDstEnc = 1'b1;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // One decoded character on its way from the front end to the emitter.
  typedef struct packed {
    logic        term;
    logic [31:0] cp;
  } cp_item_t;

  // Unused codes fall back to UTF-8.
  function automatic enc_e norm_enc(input logic [CfgDataW-1:0] e);
    enc_e r;
    unique case (e)
      3'd2:    r = EncU16Le;
      3'd3:    r = EncU16Be;
      3'd4:    r = EncU32Le;
      3'd5:    r = EncU32Be;
      default: r = EncUtf8;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/utt_intf.sv =====
// Valid/ready channel interfaces for source words and destination words.
`default_nettype none

interface utt_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface utt_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       string_end;

  modport source (output valid, output out_byte, output last_of_run, output string_end,
                  input ready);
  modport sink (input valid, input out_byte, input last_of_run, input string_end,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/utt_front.sv =====
// Front end: collects source bytes of one character, spots terminators, decodes the code point.
`default_nettype none

module utt_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               clear_i,
  input  wire utt_pkg::enc_e      src_enc_i,
  utt_in_if.sink                  src,
  input  wire logic               full_i,
  output logic                    push_o,
  output utt_pkg::cp_item_t       item_o
);

  logic [31:0] buf_q, buf_d;
  logic [2:0]  ncol_q, ncol_d;
  logic [2:0]  nexp_q, nexp_d;

  logic        accept;
  logic [31:0] buf_n;
  logic [2:0]  n;
  logic [2:0]  exp_n;
  logic        term;
  logic        done;
  logic        is16;
  logic        is32;
  logic [7:0]  hi_byte;
  logic [15:0] hi16;
  logic [15:0] lo16;
  logic [31:0] cp;

  assign src.ready = !full_i;
  assign accept    = src.valid && src.ready;

  assign is16 = (src_enc_i == utt_pkg::EncU16Le) || (src_enc_i == utt_pkg::EncU16Be);
  assign is32 = (src_enc_i == utt_pkg::EncU32Le) || (src_enc_i == utt_pkg::EncU32Be);

  always_comb begin
    buf_n   = {buf_q[23:0], src.data_byte};
    n       = ncol_q + 3'd1;
    exp_n   = nexp_q;
    term    = 1'b0;
    hi_byte = (src_enc_i == utt_pkg::EncU16Le) ? buf_n[7:0] : buf_n[15:8];

    if (n == 3'd1) begin
      if (src_enc_i == utt_pkg::EncUtf8) begin
        if (src.data_byte == 8'h00) term = 1'b1;
        if (src.data_byte < 8'h80)      exp_n = 3'd1;
        else if (src.data_byte < 8'hE0) exp_n = 3'd2;
        else if (src.data_byte < 8'hF0) exp_n = 3'd3;
        else                            exp_n = 3'd4;
      end else if (is16) begin
        exp_n = 3'd2;
      end else begin
        exp_n = 3'd4;
      end
    end
    if ((n == 3'd2) && is16) begin
      if (buf_n[15:0] == 16'h0000) term = 1'b1;
      if ((hi_byte >= 8'hD8) && (hi_byte <= 8'hDB)) exp_n = 3'd4;
    end
    if ((n == 3'd4) && is32 && (buf_n == 32'h0)) term = 1'b1;

    done = term || !((n < exp_n) && (n < 3'd4));
  end

  // In a four-byte UTF-16 character the first unit is always a high surrogate, so its
  // offset from 0xD800 is just its low ten bits.
  always_comb begin
    if (src_enc_i == utt_pkg::EncU16Le) begin
      hi16 = {buf_n[23:16], buf_n[31:24]};
      lo16 = {buf_n[7:0], buf_n[15:8]};
    end else begin
      hi16 = buf_n[31:16];
      lo16 = buf_n[15:0];
    end

    unique case (src_enc_i) inside
      utt_pkg::EncU32Be: cp = buf_n;
      utt_pkg::EncU32Le: cp = {buf_n[7:0], buf_n[15:8], buf_n[23:16], buf_n[31:24]};
      utt_pkg::EncU16Le, utt_pkg::EncU16Be: begin
        if (n == 3'd2) begin
          cp = (src_enc_i == utt_pkg::EncU16Le) ? {16'h0, buf_n[7:0], buf_n[15:8]}
                                                : {16'h0, buf_n[15:0]};
        end else begin
          cp = {12'h0, hi16[9:0], 10'h0} + {16'h0, lo16} + 32'h0000_2400;
        end
      end
      default: begin
        case (n)
          3'd1:    cp = {24'h0, buf_n[7:0]};
          3'd2:    cp = {21'h0, buf_n[12:8], buf_n[5:0]};
          3'd3:    cp = {16'h0, buf_n[19:16], buf_n[13:8], buf_n[5:0]};
          default: cp = {11'h0, buf_n[26:24], buf_n[21:16], buf_n[13:8], buf_n[5:0]};
        endcase
      end
    endcase
  end

  always_comb begin
    buf_d  = buf_q;
    ncol_d = ncol_q;
    nexp_d = nexp_q;
    if (clear_i) begin
      buf_d  = 32'h0;
      ncol_d = 3'd0;
      nexp_d = 3'd0;
    end else if (accept) begin
      if (done) begin
        buf_d  = 32'h0;
        ncol_d = 3'd0;
        nexp_d = 3'd0;
      end else begin
        buf_d  = buf_n;
        ncol_d = n;
        nexp_d = exp_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q  <= 32'h0;
      ncol_q <= 3'd0;
      nexp_q <= 3'd0;
    end else begin
      buf_q  <= buf_d;
      ncol_q <= ncol_d;
      nexp_q <= nexp_d;
    end
  end

  assign push_o      = accept && done;
  assign item_o.term = term;
  assign item_o.cp   = term ? 32'h0 : cp;

endmodule

`default_nettype wire

// ===== rtl/utt_fifo.sv =====
// Short queue of decoded characters between the front end and the emitter.
`default_nettype none

module utt_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire utt_pkg::cp_item_t  item_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output utt_pkg::cp_item_t       item_o
);

  localparam logic [utt_pkg::FifoPtrW-1:0] LastPtr = utt_pkg::FifoPtrW'(utt_pkg::FifoDepth - 1);
  localparam logic [utt_pkg::FifoCntW-1:0] FullCnt = utt_pkg::FifoCntW'(utt_pkg::FifoDepth);

  utt_pkg::cp_item_t                mem_q [utt_pkg::FifoDepth];
  logic [utt_pkg::FifoPtrW-1:0]     wptr_q, wptr_d;
  logic [utt_pkg::FifoPtrW-1:0]     rptr_q, rptr_d;
  logic [utt_pkg::FifoCntW-1:0]     cnt_q, cnt_d;
  logic                             do_push;
  logic                             do_pop;

  assign full_o  = (cnt_q == FullCnt);
  assign valid_o = (cnt_q != '0);
  assign item_o  = mem_q[rptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) wptr_d = (wptr_q == LastPtr) ? '0 : wptr_q + 1'b1;
    if (do_pop)  rptr_d = (rptr_q == LastPtr) ? '0 : rptr_q + 1'b1;
    if (do_push && !do_pop)      cnt_d = cnt_q + 1'b1;
    else if (!do_push && do_pop) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= item_i;
  end

endmodule

`default_nettype wire

// ===== rtl/utt_back.sv =====
// Back end: encodes a code point in the destination encoding and emits it word by word.
`default_nettype none

module utt_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire utt_pkg::enc_e      dst_enc_i,
  input  wire logic               item_valid_i,
  input  wire utt_pkg::cp_item_t  item_i,
  output logic                    pop_o,
  utt_out_if.source               dst
);

  typedef struct packed {
    logic [31:0] word;
    logic [1:0]  rem;
  } enc_run_t;

  // The first word of the run sits in the top byte.
  function automatic enc_run_t encode(input logic [31:0] c, input utt_pkg::enc_e e);
    enc_run_t    r;
    logic [31:0] v;
    logic [15:0] h;
    logic [15:0] l;
    v = c - 32'h0001_0000;
    h = {6'b110110, v[19:10]};
    l = {6'b110111, v[9:0]};
    unique case (e)
      utt_pkg::EncU32Le: r = '{word: {c[7:0], c[15:8], c[23:16], c[31:24]}, rem: 2'd3};
      utt_pkg::EncU32Be: r = '{word: c, rem: 2'd3};
      utt_pkg::EncU16Le: begin
        if (c <= 32'h0000_FFFF) r = '{word: {c[7:0], c[15:8], 16'h0}, rem: 2'd1};
        else r = '{word: {h[7:0], h[15:8], l[7:0], l[15:8]}, rem: 2'd3};
      end
      utt_pkg::EncU16Be: begin
        if (c <= 32'h0000_FFFF) r = '{word: {c[15:0], 16'h0}, rem: 2'd1};
        else r = '{word: {h, l}, rem: 2'd3};
      end
      default: begin
        if (c <= 32'h0000_007F) begin
          r = '{word: {c[7:0], 24'h0}, rem: 2'd0};
        end else if (c <= 32'h0000_07FF) begin
          r = '{word: {3'b110, c[10:6], 2'b10, c[5:0], 16'h0}, rem: 2'd1};
        end else if (c <= 32'h0000_FFFF) begin
          r = '{word: {4'b1110, c[15:12], 2'b10, c[11:6], 2'b10, c[5:0], 8'h0}, rem: 2'd2};
        end else begin
          r = '{word: {5'b11110, c[20:18], 2'b10, c[17:12], 2'b10, c[11:6], 2'b10, c[5:0]},
                rem: 2'd3};
        end
      end
    endcase
    return r;
  endfunction

  logic        busy_q;
  logic        out_valid_q;
  logic [31:0] word_q;
  logic [1:0]  rem_q;
  logic        term_q;
  logic [7:0]  out_byte_q;
  logic        out_last_q;
  logic        out_end_q;

  logic        adv;
  logic        load;
  enc_run_t    run;

  assign adv   = !out_valid_q || dst.ready;
  assign load  = item_valid_i && (!busy_q || (adv && (rem_q == 2'd0)));
  assign pop_o = load;

  // A terminator is always four zero words, whatever the destination encoding.
  always_comb begin
    if (item_i.term) run = '{word: 32'h0, rem: 2'd3};
    else             run = encode(item_i.cp, dst_enc_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv) out_valid_q <= busy_q;
      if (load)                                     busy_q <= 1'b1;
      else if (adv && busy_q && (rem_q == 2'd0))    busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && busy_q) begin
      out_byte_q <= word_q[31:24];
      out_last_q <= (rem_q == 2'd0);
      out_end_q  <= term_q;
    end
    if (load) begin
      word_q <= run.word;
      rem_q  <= run.rem;
      term_q <= item_i.term;
    end else if (adv && busy_q) begin
      word_q <= {word_q[23:0], 8'h0};
      rem_q  <= rem_q - 2'd1;
    end
  end

  assign dst.valid       = out_valid_q;
  assign dst.out_byte    = out_byte_q;
  assign dst.last_of_run = out_last_q;
  assign dst.string_end  = out_end_q;

endmodule

`default_nettype wire

// ===== rtl/unicode_utf_transcoder.sv =====
// Top level of the UTF transcoder: configuration registers, front end, queue and emitter.
//
// The source channel (src_i) takes one byte of the source string per word; the
// destination channel (dst_o) gives one byte of the re-encoded string per word,
// with last_of_run on the final byte of each character and string_end on the four
// zero bytes that close a string. The encodings are set through the write port
// (index 0 source, index 1 destination); the user must write them only while the
// block is idle, which the block itself does not enforce. Writing the source
// encoding drops any partly collected character. A fully collected character
// goes into the queue, then into the emitter's word register, and its first byte
// then into the output register. The front end takes one source byte per cycle
// while the queue is not full, and the emitter gives one destination byte per
// cycle while the receiver is ready.
// A queue of two decoded characters sits between the two halves; when the
// receiver stalls the queue fills and src_i.ready falls, and no word is lost.
// Reset clears the collection state, empties the queue and sets both encodings to UTF-8.
`default_nettype none

module unicode_utf_transcoder (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [utt_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [utt_pkg::CfgDataW-1:0]  cfg_data_i,
  utt_in_if.sink                             src_i,
  utt_out_if.source                          dst_o
);

  logic [utt_pkg::CfgDataW-1:0] src_enc_q;
  logic [utt_pkg::CfgDataW-1:0] dst_enc_q;
  logic                         src_wr;

  logic              push;
  logic              full;
  logic              pop;
  logic              item_valid;
  utt_pkg::cp_item_t push_item;
  utt_pkg::cp_item_t head_item;

  assign src_wr = cfg_we_i && (cfg_idx_i == utt_pkg::CfgSrcEnc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_enc_q <= utt_pkg::CfgDataW'(utt_pkg::EncUtf8);
      dst_enc_q <= utt_pkg::CfgDataW'(utt_pkg::EncUtf8);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == utt_pkg::CfgSrcEnc) src_enc_q <= cfg_data_i;
      if (cfg_idx_i == utt_pkg::CfgDstEnc) dst_enc_q <= cfg_data_i;
    end
  end

  utt_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .clear_i   (src_wr),
    .src_enc_i (utt_pkg::norm_enc(src_enc_q)),
    .src       (src_i),
    .full_i    (full),
    .push_o    (push),
    .item_o    (push_item)
  );

  utt_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .full_o  (full),
    .pop_i   (pop),
    .valid_o (item_valid),
    .item_o  (head_item)
  );

  utt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .dst_enc_i    (utt_pkg::norm_enc(dst_enc_q)),
    .item_valid_i (item_valid),
    .item_i       (head_item),
    .pop_o        (pop),
    .dst          (dst_o)
  );

endmodule

`default_nettype wire

// ===== rtl/utt_checker.sv =====
// Port-level assertions for the UTF transcoder and the bind that attaches them.
`default_nettype none

module utt_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       dst_valid_i,
  input wire logic       dst_ready_i,
  input wire logic [7:0] dst_byte_i,
  input wire logic       dst_last_i,
  input wire logic       dst_end_i
);

  // Counts terminator words taken so far in the current terminator run.
  logic [1:0] end_cnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      end_cnt_q <= 2'd0;
    end else if (dst_valid_i && dst_ready_i && dst_end_i) begin
      end_cnt_q <= dst_last_i ? 2'd0 : end_cnt_q + 2'd1;
    end
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dst_valid_i && !dst_ready_i |=> dst_valid_i && $stable(dst_byte_i) && $stable(dst_last_i)
                                    && $stable(dst_end_i))
    else $error("destination word changed while stalled");

  a_end_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dst_valid_i && dst_end_i |-> dst_byte_i == 8'h00)
    else $error("terminator word is not zero");

  a_end_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dst_valid_i && dst_end_i |-> dst_last_i == (end_cnt_q == 2'd3))
    else $error("terminator run does not close on its fourth word");

  a_end_whole: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dst_valid_i && !dst_end_i |-> end_cnt_q == 2'd0)
    else $error("character word inside a terminator run");

endmodule

bind unicode_utf_transcoder utt_checker u_utt_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .dst_valid_i (dst_o.valid),
  .dst_ready_i (dst_o.ready),
  .dst_byte_i  (dst_o.out_byte),
  .dst_last_i  (dst_o.last_of_run),
  .dst_end_i   (dst_o.string_end)
);

`default_nettype wire
